[hdl/tcs_pkg.sv]
// tcs_pkg: shared constants, codes and controller/datapath interface types
// for the text console cursor and scroll block. No dependencies.
package tcs_pkg;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;
  localparam int CELLS    = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int COLS_W   = 8;
  localparam int ROWS_W   = 7;
  localparam int CCOL_W   = 7;
  localparam int ROW_W    = 6;
  localparam int CHAR_W   = 8;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

  localparam logic [COLS_W-1:0] COLS_RESET = 8'd80;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd25;

  localparam logic CFG_TEXT_COLS = 1'b0;
  localparam logic CFG_TEXT_ROWS = 1'b1;

  typedef struct packed {
    logic load;
    logic clear;
    logic scroll_start;
    logic scroll_step;
    logic write_cell;
    logic out_load;
  } tcs_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_scroll;
    logic scroll_done;
    logic out_free;
  } tcs_stat_t;

endpackage

[hdl/tcs_ctrl.sv]
// tcs_ctrl: sequencing state machine (clear pass, accept, scroll walk,
// cell write, result hand-off). Depends on tcs_pkg.
module tcs_ctrl import tcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  tcs_stat_t stat,
  output tcs_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCROLL = 5'b00100,
    S_WRITE  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.need_scroll) begin
            cmd.scroll_start = 1'b1;
            state_next       = S_SCROLL;
          end else begin
            state_next = S_WRITE;
          end
        end
      end
      S_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (stat.scroll_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_cell = 1'b1;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

[hdl/tcs_dp.sv]
// tcs_dp: configuration registers, cursor update, cell store with its
// shared clear/scroll-copy counter, and the result register. Depends on tcs_pkg.
module tcs_dp import tcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  tcs_cmd_t          cmd,
  output tcs_stat_t         stat,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              last_in_write,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [COLS_W-1:0] cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CCOL_W-1:0] cell_col,
  output logic [ROW_W-1:0]  cell_row,
  output logic [CHAR_W-1:0] cell_char,
  output logic              cell_written,
  output logic              scrolled,
  output logic [COLS_W-1:0] cursor_col,
  output logic [ROW_W-1:0]  cursor_row,
  output logic              end_of_write
);

  logic [COLS_W-1:0] text_cols;
  logic [ROWS_W-1:0] text_rows;
  logic [COLS_W-1:0] cols_u;
  logic [ROWS_W-1:0] rows_u;
  logic [ROW_W-1:0]  last_row;

  logic [COLS_W-1:0] cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [COLS_W-1:0] c0, c1;
  logic [ROW_W-1:0]  r0, r_inc, r1;
  logic              wrap;

  logic [COLS_W-1:0] cur_col_next;
  logic [ROW_W-1:0]  cur_row_next;
  logic [CCOL_W-1:0] w_col_next;
  logic [ROW_W-1:0]  w_row_next;
  logic [CHAR_W-1:0] w_char_next;
  logic              written_next;
  logic              scroll_next;

  logic [CCOL_W-1:0] w_col;
  logic [ROW_W-1:0]  w_row;
  logic [CHAR_W-1:0] w_char;
  logic              w_written;
  logic              w_scrolled;
  logic              w_last;

  logic [CHAR_W-1:0] mem [CELLS];
  logic [ADDR_W-1:0] scnt;
  logic [ADDR_W-1:0] scroll_len;
  logic [ADDR_W-1:0] pend_addr;
  logic              pend;
  logic [ADDR_W-1:0] rd_addr;
  logic [CHAR_W-1:0] rdata;
  logic [ADDR_W-1:0] cell_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [CHAR_W-1:0] mem_wd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_cols <= COLS_RESET;
      text_rows <= ROWS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TEXT_COLS: text_cols <= cfg_data;
        CFG_TEXT_ROWS: text_rows <= cfg_data[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped screen geometry
  always_comb begin
    if (text_cols == '0) begin
      cols_u = COLS_W'(1);
    end else if (text_cols > COLS_W'(MAX_COLS)) begin
      cols_u = COLS_W'(MAX_COLS);
    end else begin
      cols_u = text_cols;
    end
    if (text_rows < ROWS_W'(2)) begin
      rows_u = ROWS_W'(2);
    end else if (text_rows > ROWS_W'(MAX_ROWS)) begin
      rows_u = ROWS_W'(MAX_ROWS);
    end else begin
      rows_u = text_rows;
    end
    last_row = ROW_W'(rows_u - ROWS_W'(1));
  end

  // cursor step
  always_comb begin
    c0    = (cur_col > cols_u) ? cols_u : cur_col;
    r0    = (cur_row > last_row) ? last_row : cur_row;
    r_inc = (r0 < last_row) ? r0 + ROW_W'(1) : r0;
    wrap  = (c0 >= cols_u);
    c1    = wrap ? '0 : c0;
    r1    = wrap ? r_inc : r0;

    cur_col_next = c0;
    cur_row_next = r0;
    w_col_next   = '0;
    w_row_next   = '0;
    w_char_next  = '0;
    written_next = 1'b0;
    scroll_next  = 1'b0;
    case (char_code)
      CH_NEWLINE: begin
        cur_col_next = '0;
        cur_row_next = r_inc;
      end
      CH_RETURN: begin
        cur_col_next = '0;
      end
      CH_BACKSPACE: begin
        cur_col_next = (c0 != '0) ? c0 - COLS_W'(1) : '0;
        w_col_next   = cur_col_next[CCOL_W-1:0];
        w_row_next   = r0;
        w_char_next  = CH_BACKSPACE;
        written_next = 1'b1;
      end
      default: begin
        scroll_next  = (r1 >= last_row);
        cur_row_next = scroll_next ? last_row - ROW_W'(1) : r1;
        cur_col_next = c1 + COLS_W'(1);
        w_col_next   = c1[CCOL_W-1:0];
        w_row_next   = cur_row_next;
        w_char_next  = char_code;
        written_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
    end else if (cmd.load) begin
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_col      <= w_col_next;
      w_row      <= w_row_next;
      w_char     <= w_char_next;
      w_written  <= written_next;
      w_scrolled <= scroll_next;
      w_last     <= last_in_write;
    end
  end

  // scroll copy length: (rows-1)*cols cells
  always_ff @(posedge clk) begin
    scroll_len <= ADDR_W'(last_row) * ADDR_W'(cols_u);
  end

  // clear sweep and scroll copy share one counter
  always_ff @(posedge clk) begin
    if (rst) begin
      scnt <= '0;
      pend <= 1'b0;
    end else if (cmd.clear) begin
      scnt <= scnt + ADDR_W'(1);
    end else if (cmd.scroll_start) begin
      scnt <= '0;
      pend <= 1'b0;
    end else if (cmd.scroll_step) begin
      if (scnt != scroll_len) begin
        scnt <= scnt + ADDR_W'(1);
        pend <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= scnt;
  end

  assign rd_addr   = scnt + ADDR_W'(cols_u);
  assign cell_addr = ADDR_W'(w_row) * ADDR_W'(cols_u) + ADDR_W'(w_col);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cell_addr;
    mem_wd = w_char;
    if (cmd.clear) begin
      mem_we = 1'b1;
      mem_wa = scnt;
      mem_wd = '0;
    end else if (cmd.scroll_step) begin
      mem_we = pend;
      mem_wa = pend_addr;
      mem_wd = rdata;
    end else if (cmd.write_cell) begin
      mem_we = w_written;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[rd_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cell_col     <= w_col;
      cell_row     <= w_row;
      cell_char    <= w_char;
      cell_written <= w_written;
      scrolled     <= w_scrolled;
      cursor_col   <= cur_col;
      cursor_row   <= cur_row;
      end_of_write <= w_last;
    end
  end

  assign stat.clear_last  = (scnt == ADDR_W'(CELLS - 1));
  assign stat.need_scroll = scroll_next;
  assign stat.scroll_done = (scnt == scroll_len) && !pend;
  assign stat.out_free    = !out_valid || out_ready;

endmodule

[hdl/text_console_cursor_scroll.sv]
// Text console cursor, wrap and scroll: one character byte in, one cell
// write report out. Built from tcs_ctrl and tcs_dp; depends on tcs_pkg.
//
// Usage:
//   input channel (in_valid/in_ready): char_code and last_in_write, one
//   transfer per character. 10 is newline, 13 return, 8 backspace, every
//   other byte is stored at the cursor after a wrap at the line end.
//   output channel (out_valid/out_ready): one result per character with
//   the written cell, the new cursor and the end_of_write echo.
//   config channel (cfg_valid/cfg_ready, always ready): cfg_index 0 writes
//   text_cols, 1 writes text_rows; write only while the block is idle.
// Timing:
//   with no scroll a character goes via the write state to the result
//   register; the next is taken once that result is loaded. A scroll walks
//   the cell store one cell per cycle through one read and one write port.
// Reset:
//   cursor goes to 0,0 and geometry to 80x25; a clearing pass then zeroes
//   all 8192 cells, during which in_ready stays low.
// Stall:
//   the result register holds while out_ready is low; the next character
//   is still taken and runs until its own result needs that register.
module text_console_cursor_scroll import tcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              last_in_write,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CCOL_W-1:0] cell_col,
  output logic [ROW_W-1:0]  cell_row,
  output logic [CHAR_W-1:0] cell_char,
  output logic              cell_written,
  output logic              scrolled,
  output logic [COLS_W-1:0] cursor_col,
  output logic [ROW_W-1:0]  cursor_row,
  output logic              end_of_write,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [COLS_W-1:0] cfg_data
);

  tcs_cmd_t  cmd;
  tcs_stat_t stat;

  tcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcs_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .char_code     (char_code),
    .last_in_write (last_in_write),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cell_col      (cell_col),
    .cell_row      (cell_row),
    .cell_char     (cell_char),
    .cell_written  (cell_written),
    .scrolled      (scrolled),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .end_of_write  (end_of_write)
  );

endmodule
